// ===== design/dcf_pkg.sv =====
// Shared types, constants and helpers of the difference constraint feasibility core.
`default_nettype none

package dcf_pkg;

   localparam int VAR_BITS      = 6;
   localparam int NUM_VERTICES  = 1 << VAR_BITS;
   localparam int BOUND_BITS    = 16;
   localparam int DIST_BITS     = 24;
   localparam int SUM_BITS      = DIST_BITS + 1;
   localparam int MAX_EDGES_DEF = 256;

   typedef logic [VAR_BITS-1:0]          vert_type;
   typedef logic signed [BOUND_BITS-1:0] wt_type;
   typedef logic signed [DIST_BITS-1:0]  dist_type;
   typedef logic signed [SUM_BITS-1:0]   sum_type;

   localparam wt_type   BOUND_MAX = {1'b0, {(BOUND_BITS-1){1'b1}}};
   localparam wt_type   BOUND_MIN = {1'b1, {(BOUND_BITS-1){1'b0}}};
   localparam dist_type DIST_MAX  = {1'b0, {(DIST_BITS-1){1'b1}}};
   localparam dist_type DIST_MIN  = {1'b1, {(DIST_BITS-1){1'b0}}};
   localparam dist_type DIST_ZERO = '0;

   typedef struct packed {
      vert_type src;
      vert_type dst;
      wt_type   wt;
   } edge_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_CLEAR,
      ST_EDGE,
      ST_COPY,
      ST_DONE
   } state_type;

   // Port controls of the two distance memories.
   typedef struct packed {
      vert_type cur_rd_addr;
      vert_type nxt_rd_addr;
      logic     cur_we;
      vert_type cur_wr_addr;
      dist_type cur_wr_data;
      logic     nxt_we;
      vert_type nxt_wr_addr;
      dist_type nxt_wr_data;
   } dist_ctl_type;

   // Last write to the next-distance memory, for read-after-write bypass.
   typedef struct packed {
      logic     valid;
      vert_type dst;
      dist_type data;
   } fwd_type;

   function automatic dist_type sat_dist(input sum_type s);
      dist_type r;
      if (s[SUM_BITS-1] != s[SUM_BITS-2]) begin
         r = s[SUM_BITS-1] ? DIST_MIN : DIST_MAX;
      end else begin
         r = s[DIST_BITS-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== design/dcf_if.sv =====
// Handshake channels for constraint items and verdict items.
`default_nettype none

interface dcf_req_if;
   logic                       valid;
   logic                       ready;
   logic [dcf_pkg::VAR_BITS-1:0] var_left;
   logic [dcf_pkg::VAR_BITS-1:0] var_right;
   logic                       is_ge;
   logic signed [dcf_pkg::BOUND_BITS-1:0] bound;
   logic                       last_constraint;

   modport source (output valid, var_left, var_right, is_ge, bound, last_constraint,
                   input ready);
   modport sink   (input valid, var_left, var_right, is_ge, bound, last_constraint,
                   output ready);
endinterface

interface dcf_rsp_if;
   logic valid;
   logic ready;
   logic infeasible;
   logic edges_dropped;

   modport source (output valid, infeasible, edges_dropped, input ready);
   modport sink   (input valid, infeasible, edges_dropped, output ready);
endinterface

`default_nettype wire

// ===== design/dcf_edge_store.sv =====
// Edge memory: one write port, one read port with registered data.
`default_nettype none

module dcf_edge_store #(
   parameter int MAX_EDGES = dcf_pkg::MAX_EDGES_DEF,
   parameter int ADDR_BITS = $clog2(MAX_EDGES)
) (
   input  wire logic                 clock,
   input  wire logic                 we,
   input  wire logic [ADDR_BITS-1:0] waddr,
   input  wire dcf_pkg::edge_type    wdata,
   input  wire logic [ADDR_BITS-1:0] raddr,
   output dcf_pkg::edge_type         rdata
);
   import dcf_pkg::*;

   edge_type edge_mem_ff [MAX_EDGES];
   edge_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         edge_mem_ff[waddr] <= wdata;
      end
      rdata_ff <= edge_mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== design/dcf_dist_store.sv =====
// Current and next distance memories, each with one write and one registered read port.
`default_nettype none

module dcf_dist_store (
   input  wire logic                  clock,
   input  wire dcf_pkg::dist_ctl_type ctl,
   output dcf_pkg::dist_type          cur_q,
   output dcf_pkg::dist_type          nxt_q
);
   import dcf_pkg::*;

   dist_type cur_mem_ff [NUM_VERTICES];
   dist_type nxt_mem_ff [NUM_VERTICES];
   dist_type cur_q_ff;
   dist_type nxt_q_ff;

   always_ff @(posedge clock) begin
      if (ctl.cur_we) begin
         cur_mem_ff[ctl.cur_wr_addr] <= ctl.cur_wr_data;
      end
      cur_q_ff <= cur_mem_ff[ctl.cur_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (ctl.nxt_we) begin
         nxt_mem_ff[ctl.nxt_wr_addr] <= ctl.nxt_wr_data;
      end
      nxt_q_ff <= nxt_mem_ff[ctl.nxt_rd_addr];
   end

   assign cur_q = cur_q_ff;
   assign nxt_q = nxt_q_ff;

endmodule

`default_nettype wire

// ===== design/dcf_relax_alu.sv =====
// Edge relaxation: saturating candidate, bypass of the last write, minimum.
`default_nettype none

module dcf_relax_alu (
   input  wire dcf_pkg::dist_type cur_dist,
   input  wire dcf_pkg::dist_type nxt_dist,
   input  wire dcf_pkg::wt_type   wt,
   input  wire dcf_pkg::vert_type dst,
   input  wire dcf_pkg::fwd_type  fwd,
   output dcf_pkg::dist_type      new_dist
);
   import dcf_pkg::*;

   dist_type nxt_eff;
   sum_type  sum;
   dist_type cand;

   always_comb begin
      // take the previous edge's write when it hit the same vertex
      nxt_eff = (fwd.valid && (fwd.dst == dst)) ? fwd.data : nxt_dist;
      sum     = {cur_dist[DIST_BITS-1], cur_dist}
              + {{(SUM_BITS-BOUND_BITS){wt[BOUND_BITS-1]}}, wt};
      cand    = sat_dist(sum);
      new_dist = (cand < nxt_eff) ? cand : nxt_eff;
   end

endmodule

`default_nettype wire

// ===== design/difference_constraint_feasibility_core.sv =====
// Top level: constraint loading, Bellman-Ford rounds and verdict output.
// Constraint items that are not last are taken one per cycle in the load state and give no item.
// A last item starts the check; with S the highest vertex index, the verdict follows a clear
// pass and S+1 rounds, each a one edge per cycle relaxation pass and a vertex copy pass
// through the distance memories; no constraint item is taken until the verdict is registered.
// Reset (synchronous): empty edge set, no pending verdict; memories are not cleared.
`default_nettype none

module difference_constraint_feasibility_core #(
   parameter int MAX_EDGES = dcf_pkg::MAX_EDGES_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   dcf_req_if.sink    req_ch,
   dcf_rsp_if.source  rsp_ch
);
   import dcf_pkg::*;

   localparam int EDGE_AW = $clog2(MAX_EDGES);
   localparam int CNT_W   = $clog2(MAX_EDGES + 1);

   // ------------------------------------------------------------------
   // State
   // ------------------------------------------------------------------
   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     edge_count_ff, edge_count_in;
   vert_type             span_ff, span_in;
   logic                 overflow_ff, overflow_in;
   logic [EDGE_AW-1:0]   eidx_ff, eidx_in;
   vert_type             vidx_ff, vidx_in;
   vert_type             round_ff, round_in;
   logic                 issue_act_ff, issue_act_in;
   logic                 s1_valid_ff, s1_valid_in;
   logic                 s2_valid_ff, s2_valid_in;
   vert_type             s2_dst_ff, s2_dst_in;
   wt_type               s2_wt_ff, s2_wt_in;
   fwd_type              fwd_ff, fwd_in;
   logic                 copy_valid_ff, copy_valid_in;
   vert_type             copy_addr_ff, copy_addr_in;
   logic                 lowered_ff, lowered_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_infeasible_ff, rsp_infeasible_in;
   logic                 rsp_dropped_ff, rsp_dropped_in;

   logic                 req_accept;
   logic                 edge_done;
   logic                 copy_done;
   logic                 slot_free;
   logic                 edge_we;
   edge_type             edge_wdata;
   edge_type             edge_q;
   wt_type               neg_bound;
   dist_ctl_type         dist_ctl;
   dist_type             cur_q;
   dist_type             nxt_q;
   dist_type             new_dist;

   // ------------------------------------------------------------------
   // Submodules
   // ------------------------------------------------------------------
   dcf_edge_store #(
      .MAX_EDGES (MAX_EDGES),
      .ADDR_BITS (EDGE_AW)
   ) u_edge_store (
      .clock (clock),
      .we    (edge_we),
      .waddr (edge_count_ff[EDGE_AW-1:0]),
      .wdata (edge_wdata),
      .raddr (eidx_ff),
      .rdata (edge_q)
   );

   dcf_dist_store u_dist_store (
      .clock (clock),
      .ctl   (dist_ctl),
      .cur_q (cur_q),
      .nxt_q (nxt_q)
   );

   dcf_relax_alu u_relax_alu (
      .cur_dist (cur_q),
      .nxt_dist (nxt_q),
      .wt       (s2_wt_ff),
      .dst      (s2_dst_ff),
      .fwd      (fwd_ff),
      .new_dist (new_dist)
   );

   // ------------------------------------------------------------------
   // Handshake and pass status
   // ------------------------------------------------------------------
   assign req_ch.ready     = (state_ff == ST_LOAD);
   assign req_accept       = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.infeasible    = rsp_infeasible_ff;
   assign rsp_ch.edges_dropped = rsp_dropped_ff;

   // edge pass is over once nothing is issued and both stages are empty
   assign edge_done = !issue_act_ff && !s1_valid_ff && !s2_valid_ff;
   assign copy_done = !issue_act_ff && !copy_valid_ff;
   // the verdict register may be loaded when empty or being emptied now
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;

   // GE constraint: reversed edge with negated bound, saturated at the top
   assign neg_bound = (req_ch.bound == BOUND_MIN) ? BOUND_MAX : -req_ch.bound;

   always_comb begin
      if (req_ch.is_ge) begin
         edge_wdata.src = req_ch.var_right;
         edge_wdata.dst = req_ch.var_left;
         edge_wdata.wt  = neg_bound;
      end else begin
         edge_wdata.src = req_ch.var_left;
         edge_wdata.dst = req_ch.var_right;
         edge_wdata.wt  = req_ch.bound;
      end
   end

   // ------------------------------------------------------------------
   // Next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_accept && req_ch.last_constraint) begin
               state_in = ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            if (vidx_ff == span_ff) begin
               state_in = ST_EDGE;
            end
         end
         ST_EDGE: begin
            if (edge_done) begin
               state_in = ST_COPY;
            end
         end
         ST_COPY: begin
            if (copy_done) begin
               state_in = (round_ff == span_ff) ? ST_DONE : ST_EDGE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // ------------------------------------------------------------------
   // Datapath control and next values
   // ------------------------------------------------------------------
   always_comb begin
      edge_count_in     = edge_count_ff;
      span_in           = span_ff;
      overflow_in       = overflow_ff;
      eidx_in           = eidx_ff;
      vidx_in           = vidx_ff;
      round_in          = round_ff;
      issue_act_in      = issue_act_ff;
      s1_valid_in       = 1'b0;
      s2_valid_in       = 1'b0;
      s2_dst_in         = edge_q.dst;
      s2_wt_in          = edge_q.wt;
      fwd_in            = '0;
      copy_valid_in     = 1'b0;
      copy_addr_in      = vidx_ff;
      lowered_in        = lowered_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ch.ready;
      rsp_infeasible_in = rsp_infeasible_ff;
      rsp_dropped_in    = rsp_dropped_ff;
      edge_we           = 1'b0;

      dist_ctl.cur_rd_addr = vidx_ff;
      dist_ctl.nxt_rd_addr = vidx_ff;
      dist_ctl.cur_we      = 1'b0;
      dist_ctl.cur_wr_addr = vidx_ff;
      dist_ctl.cur_wr_data = DIST_ZERO;
      dist_ctl.nxt_we      = 1'b0;
      dist_ctl.nxt_wr_addr = vidx_ff;
      dist_ctl.nxt_wr_data = DIST_ZERO;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_accept) begin
               if (edge_count_ff < CNT_W'(MAX_EDGES)) begin
                  edge_we       = 1'b1;
                  edge_count_in = edge_count_ff + 1'b1;
                  if (req_ch.var_left > span_in) begin
                     span_in = req_ch.var_left;
                  end
                  if (req_ch.var_right > span_in) begin
                     span_in = req_ch.var_right;
                  end
               end else begin
                  // store full: drop the item, remember it
                  overflow_in = 1'b1;
               end
               if (req_ch.last_constraint) begin
                  vidx_in = '0;
               end
            end
         end

         ST_CLEAR: begin
            // zero both distance copies for every vertex in use
            dist_ctl.cur_we = 1'b1;
            dist_ctl.nxt_we = 1'b1;
            vidx_in         = vidx_ff + 1'b1;
            if (vidx_ff == span_ff) begin
               eidx_in      = '0;
               issue_act_in = (edge_count_ff != '0);
               round_in     = '0;
            end
         end

         ST_EDGE: begin
            // issue: read one edge per cycle
            if (issue_act_ff) begin
               s1_valid_in = 1'b1;
               if (CNT_W'(eidx_ff) == edge_count_ff - 1'b1) begin
                  issue_act_in = 1'b0;
               end else begin
                  eidx_in = eidx_ff + 1'b1;
               end
            end
            // stage 1: edge word is here, read both distances
            dist_ctl.cur_rd_addr = edge_q.src;
            dist_ctl.nxt_rd_addr = edge_q.dst;
            s2_valid_in          = s1_valid_ff;
            // stage 2: relax and write back the minimum
            dist_ctl.nxt_we      = s2_valid_ff;
            dist_ctl.nxt_wr_addr = s2_dst_ff;
            dist_ctl.nxt_wr_data = new_dist;
            fwd_in.valid         = s2_valid_ff;
            fwd_in.dst           = s2_dst_ff;
            fwd_in.data          = new_dist;
            if (edge_done) begin
               vidx_in      = '0;
               issue_act_in = 1'b1;
               lowered_in   = 1'b0;
            end
         end

         ST_COPY: begin
            // issue: read both copies of one vertex per cycle
            if (issue_act_ff) begin
               copy_valid_in = 1'b1;
               if (vidx_ff == span_ff) begin
                  issue_act_in = 1'b0;
               end else begin
                  vidx_in = vidx_ff + 1'b1;
               end
            end
            // data stage: note any lowered distance, advance current copy
            dist_ctl.cur_we      = copy_valid_ff;
            dist_ctl.cur_wr_addr = copy_addr_ff;
            dist_ctl.cur_wr_data = nxt_q;
            if (copy_valid_ff && (cur_q != nxt_q)) begin
               lowered_in = 1'b1;
            end
            if (copy_done && (round_ff != span_ff)) begin
               round_in     = round_ff + 1'b1;
               eidx_in      = '0;
               issue_act_in = (edge_count_ff != '0);
            end
         end

         ST_DONE: begin
            // the extra round decides; then start a fresh set
            if (slot_free) begin
               rsp_valid_in      = 1'b1;
               rsp_infeasible_in = lowered_ff;
               rsp_dropped_in    = overflow_ff;
               edge_count_in     = '0;
               span_in           = '0;
               overflow_in       = 1'b0;
            end
         end

         default: begin
            issue_act_in = 1'b0;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         edge_count_ff <= '0;
         span_ff       <= '0;
         overflow_ff   <= 1'b0;
         issue_act_ff  <= 1'b0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         fwd_ff.valid  <= 1'b0;
         copy_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         edge_count_ff <= edge_count_in;
         span_ff       <= span_in;
         overflow_ff   <= overflow_in;
         issue_act_ff  <= issue_act_in;
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
         fwd_ff.valid  <= fwd_in.valid;
         copy_valid_ff <= copy_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      eidx_ff           <= eidx_in;
      vidx_ff           <= vidx_in;
      round_ff          <= round_in;
      s2_dst_ff         <= s2_dst_in;
      s2_wt_ff          <= s2_wt_in;
      fwd_ff.dst        <= fwd_in.dst;
      fwd_ff.data       <= fwd_in.data;
      copy_addr_ff      <= copy_addr_in;
      lowered_ff        <= lowered_in;
      rsp_infeasible_ff <= rsp_infeasible_in;
      rsp_dropped_ff    <= rsp_dropped_in;
   end

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      edge_count_ff <= CNT_W'(MAX_EDGES))
      else $error("edge count above store depth");

   a_relax_in_edge: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff || s2_valid_ff) |-> (state_ff == ST_EDGE))
      else $error("relaxation stage busy outside edge pass");

   a_copy_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COPY && state_in != ST_COPY) |-> (!copy_valid_ff && !issue_act_ff))
      else $error("copy pass left before draining");

   a_set_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && state_in == ST_LOAD)
         |=> (edge_count_ff == '0 && !overflow_ff && rsp_valid_ff))
      else $error("verdict not loaded or edge set not cleared");

endmodule

`default_nettype wire

// ===== verif/dcf_verdict_check.sv =====
`timescale 1ns / 1ps
// Verdict predictor and comparator for the difference constraint feasibility core.
module dcf_verdict_check #(
   parameter int EDGE_CAP = dcf_pkg::MAX_EDGES_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   dcf_req_if        req_mon,
   dcf_rsp_if        rsp_mon,
   output int        mismatch_count,
   output int        verdicts_pending
);
   import dcf_pkg::*;

   typedef struct packed {
      logic infeasible;
      logic edges_dropped;
   } verdict_type;

   edge_type    edge_mem [EDGE_CAP];
   int          edge_total;
   vert_type    span_hi;
   logic        dropped_seen;
   int          errors;
   verdict_type verdict_q [$];

   initial begin
      errors = 0;
      edge_total = 0;
      span_hi = '0;
      dropped_seen = 1'b0;
      mismatch_count = 0;
      verdicts_pending = 0;
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      errors++;
   endtask

   // Jacobi relaxation from all-zero distances over the stored edges; true when
   // the extra round after span_hi rounds still lowers a distance.
   function automatic logic negative_cycle_found();
      dist_type dist_now [NUM_VERTICES];
      dist_type nxt      [NUM_VERTICES];
      longint   sum;
      dist_type cand;
      logic     lowered;
      int       round_no;
      int       e;
      int       v;
      lowered = 1'b0;
      for (v = 0; v < NUM_VERTICES; v++) dist_now[v] = DIST_ZERO;
      for (round_no = 0; round_no <= int'(span_hi); round_no++) begin
         lowered = 1'b0;
         nxt = dist_now;
         for (e = 0; e < edge_total; e++) begin
            sum = longint'(dist_now[edge_mem[e].src]) + longint'(edge_mem[e].wt);
            if (sum > longint'(DIST_MAX)) begin
               cand = DIST_MAX;
            end else if (sum < longint'(DIST_MIN)) begin
               cand = DIST_MIN;
            end else begin
               cand = dist_type'(sum);
            end
            if (cand < nxt[edge_mem[e].dst]) nxt[edge_mem[e].dst] = cand;
         end
         for (v = 0; v < NUM_VERTICES; v++) begin
            if (nxt[v] != dist_now[v]) lowered = 1'b1;
         end
         dist_now = nxt;
      end
      return lowered;
   endfunction

   always @(posedge clock) begin
      verdict_type want;
      edge_type    fresh;
      if (reset) begin
         edge_total = 0;
         span_hi = '0;
         dropped_seen = 1'b0;
         verdict_q.delete();
      end else begin
         // compare first, so a verdict never matches an item taken at the same edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (verdict_q.size() == 0) begin
               report_mismatch($sformatf("verdict item with none pending (infeasible=%b dropped=%b)",
                                         rsp_mon.infeasible, rsp_mon.edges_dropped));
            end else begin
               want = verdict_q.pop_front();
               if (rsp_mon.infeasible !== want.infeasible)
                  report_mismatch($sformatf("infeasible: got %b, predicted %b",
                                            rsp_mon.infeasible, want.infeasible));
               if (rsp_mon.edges_dropped !== want.edges_dropped)
                  report_mismatch($sformatf("edges_dropped: got %b, predicted %b",
                                            rsp_mon.edges_dropped, want.edges_dropped));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (edge_total < EDGE_CAP) begin
               if (req_mon.is_ge) begin
                  fresh.src = req_mon.var_right;
                  fresh.dst = req_mon.var_left;
                  fresh.wt  = (req_mon.bound == BOUND_MIN) ? BOUND_MAX : wt_type'(-req_mon.bound);
               end else begin
                  fresh.src = req_mon.var_left;
                  fresh.dst = req_mon.var_right;
                  fresh.wt  = req_mon.bound;
               end
               edge_mem[edge_total] = fresh;
               edge_total++;
               if (req_mon.var_left > span_hi) span_hi = req_mon.var_left;
               if (req_mon.var_right > span_hi) span_hi = req_mon.var_right;
            end else begin
               dropped_seen = 1'b1;
            end
            if (req_mon.last_constraint) begin
               want.infeasible    = negative_cycle_found();
               want.edges_dropped = dropped_seen;
               verdict_q = {verdict_q, want};
               edge_total = 0;
               span_hi = '0;
               dropped_seen = 1'b0;
            end
         end
      end
      mismatch_count   <= errors;
      verdicts_pending <= verdict_q.size();
   end

endmodule

// ===== verif/difference_constraint_feasibility_core_test.sv =====
`timescale 1ns / 1ps
// Testbench top: clock, reset, constraint stimulus, verdict backpressure, watchdog and final verdict.
module difference_constraint_feasibility_core_test;
   import dcf_pkg::*;

   localparam int EDGE_CAP     = MAX_EDGES_DEF;
   localparam int RANDOM_ITEMS = 1100;
   // Watchdog limit, set well beyond the check of a full store with the widest vertex span.
   localparam int STALL_LIMIT  = 100000;
   localparam int HOLD_AFTER   = 10;
   localparam int HOLD_CYCLES  = 3000;
   localparam int DRAIN_CYCLES = 200;

   logic clock;
   logic reset;
   logic steady;
   int   mismatch_total;
   int   verdicts_open;
   int   quiet_cycles = 0;

   dcf_req_if req_ch ();
   dcf_rsp_if rsp_ch ();

   difference_constraint_feasibility_core #(
      .MAX_EDGES (EDGE_CAP)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Predicts each verdict and compares it; reports back the error and pending counts.
   dcf_verdict_check #(
      .EDGE_CAP (EDGE_CAP)
   ) verdict_check (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_ch),
      .rsp_mon          (rsp_ch),
      .mismatch_count   (mismatch_total),
      .verdicts_pending (verdicts_open)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Mostly small bounds so that sets are often feasible; now and then the extremes.
   function automatic wt_type pick_bound();
      case ($urandom_range(19))
         0:             return BOUND_MIN;
         1:             return BOUND_MAX;
         2:             return wt_type'(-BOUND_MAX);
         3, 4, 5, 6:    return wt_type'($urandom);
         7, 8, 9, 10,
         11, 12, 13, 14: return wt_type'($urandom_range(60));
         default:       return wt_type'(int'($urandom_range(16)) - 8);
      endcase
   endfunction

   function automatic vert_type pick_vertex(input int hi);
      return vert_type'($urandom_range(hi));
   endfunction

   // Offer one constraint item and hold it until the core takes it. Called at a
   // rising edge; returns at the edge where the item was accepted.
   task automatic send_constraint(input vert_type left, input vert_type right, input logic ge,
                                  input wt_type bound, input logic fin);
      while (!steady && $urandom_range(99) < 33) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid           <= 1'b1;
      req_ch.var_left        <= left;
      req_ch.var_right       <= right;
      req_ch.is_ge           <= ge;
      req_ch.bound           <= bound;
      req_ch.last_constraint <= fin;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
   endtask

   // One complete constraint set over vertices 0..hi, closed by its last item.
   task automatic send_constraint_set(input int len, input int hi);
      int i;
      for (i = 0; i < len; i++) begin
         send_constraint(pick_vertex(hi), pick_vertex(hi), logic'($urandom_range(1)),
                         pick_bound(), i == len - 1);
      end
   endtask

   // Hold the sender until every predicted verdict has come back.
   task automatic wait_for_verdicts();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (verdicts_open != 0) @(posedge clock);
   endtask

   // Constraint stimulus and final verdict.
   initial begin
      int sent;
      int set_idx;
      int set_len;
      int hi_vert;
      reset                  <= 1'b1;
      steady                 <= 1'b0;
      req_ch.valid           <= 1'b0;
      req_ch.var_left        <= '0;
      req_ch.var_right       <= '0;
      req_ch.is_ge           <= 1'b0;
      req_ch.bound           <= '0;
      req_ch.last_constraint <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // zero-weight self loop on vertex 0: feasible, a single round
      send_constraint(6'd0, 6'd0, 1'b0, wt_type'(0), 1'b1);
      // negative self loop: infeasible
      send_constraint(6'd5, 6'd5, 1'b0, wt_type'(-1), 1'b1);
      // GE on the most negative bound: the negated weight saturates, lone edge is feasible
      send_constraint(6'd1, 6'd2, 1'b1, BOUND_MIN, 1'b1);
      // cycle of -32768 and the saturated +32767: infeasible only because of saturation
      send_constraint(6'd1, 6'd2, 1'b0, BOUND_MIN, 1'b0);
      send_constraint(6'd1, 6'd2, 1'b1, BOUND_MIN, 1'b1);
      // x0 - x1 <= 2 together with x0 - x1 >= 3: infeasible
      send_constraint(6'd0, 6'd1, 1'b0, wt_type'(2), 1'b0);
      send_constraint(6'd0, 6'd1, 1'b1, wt_type'(3), 1'b1);
      // widest span: zero cycle between 63 and 0, then a GE self loop that goes negative
      send_constraint(6'd63, 6'd0, 1'b0, BOUND_MAX, 1'b0);
      send_constraint(6'd0, 6'd63, 1'b0, wt_type'(-BOUND_MAX), 1'b0);
      send_constraint(6'd63, 6'd63, 1'b1, BOUND_MAX, 1'b1);
      // feasible pair on mid-range vertices with alternating index bits
      send_constraint(6'd42, 6'd21, 1'b1, wt_type'(-1), 1'b0);
      send_constraint(6'd21, 6'd42, 1'b0, wt_type'(1), 1'b1);
      wait_for_verdicts();

      sent = 0;
      set_idx = 0;
      while (sent < RANDOM_ITEMS) begin
         set_idx++;
         // long stretch without idling on either side
         if (set_idx == 26) steady <= 1'b1;
         if (set_idx == 41) steady <= 1'b0;
         if (set_idx == 8 || set_idx == 20 || set_idx == 34) begin
            // store-full sets, each started from an idle core: exactly full, dropped
            // on the last item, and dropped several times
            wait_for_verdicts();
            case (set_idx)
               8:       begin set_len = EDGE_CAP;                          hi_vert = 63; end
               20:      begin set_len = EDGE_CAP + 1;                      hi_vert = 7;  end
               default: begin set_len = EDGE_CAP + $urandom_range(2, 8);   hi_vert = 15; end
            endcase
         end else begin
            set_len = $urandom_range(1, 10);
            case ($urandom_range(9))
               0:       hi_vert = 63;
               1, 2:    hi_vert = 15;
               default: hi_vert = 7;
            endcase
         end
         send_constraint_set(set_len, hi_vert);
         sent += set_len;
      end
      req_ch.valid <= 1'b0;

      // drain, then give a stray verdict item time to show up
      wait_for_verdicts();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_total == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Verdict backpressure: random ready, once a long hold-off so that the core
   // fills up behind a finished verdict and stalls its constraint input.
   initial begin
      int  seen;
      logic held;
      seen = 0;
      held = 1'b0;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (rsp_ch.valid && rsp_ch.ready) seen++;
         if (!held && seen == HOLD_AFTER) begin
            held = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ch.ready <= steady || ($urandom_range(99) >= 33);
            @(posedge clock);
         end
      end
   end

   // Watchdog: end the run when no item moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("TIMEOUT: no item accepted for %0d cycles", STALL_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
